/* rtl/core/baro_temp_compensation_macros.svh */
// Assertion macros for the compensation engine.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BARO_TEMP_COMPENSATION_MACROS_SVH
`define BARO_TEMP_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
// Property checked every edge outside reset
`define BTC_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Antecedent this edge implies consequent at the next edge
`define BTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTC_ASSERT_NOW(lbl, prop, msg)
`define BTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/btc_pkg.sv */
package btc_pkg;

    // Default depth of the sample queue between front and back
    localparam int BTC_QUEUE_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CALIB  = 2'd0,
        CFG_PRESS_LOW   = 2'd1,
        CFG_PRESS_HIGH  = 2'd2,
        CFG_PRESS_LAST  = 2'd3
    } t_cfg_idx;

    // Compensation constants
    localparam logic [63:0] FINE_OFFSET   = 64'd128000;
    localparam logic [20:0] PRESS_FULL    = 21'd1048576;
    localparam logic [63:0] PRESS_SCALE   = 64'd3125;
    localparam logic [63:0] DEN_BIAS      = 64'd1 << 47;
    localparam int          P4_SHIFT      = 35;
    localparam int          P5_SHIFT      = 17;

    // Classified sample as it sits in the queue
    typedef struct packed {
        logic [17:0] a;      // (adc_t >> 3) - 2*t1, signed
        logic [16:0] b;      // (adc_t >> 4) - t1, signed
        logic [19:0] adc_p;
    } t_item;

    // Unpacked calibration words
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_calib;

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32_64(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

/* rtl/core/baro_temp_compensation.sv */
// Barometric compensation engine. Push one raw pressure/temperature pair per
// transaction; each yields one result (temperature in 0.01 degree, pressure in
// Pa as Q24.8, and an invalid flag when the pressure divisor is zero). One
// transaction per clock is sustained while results are popped; between the
// input queue and the output register most of the pipeline is the 64-stage
// one-bit-per-stage divider. The input queue holds QUEUE_DEPTH samples, so
// push keeps being taken while a result waits, until the queue is full; when
// results are not popped the whole pipeline holds. Write calibration only
// while no sample is in flight.
`include "baro_temp_compensation_macros.svh"
module baro_temp_compensation #(
    parameter int QUEUE_DEPTH = btc_pkg::BTC_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [19:0]                      i_pressure_raw,
    input  logic [19:0]                      i_temperature_raw,
    output logic                             empty,
    input  logic                             pop,
    output logic [31:0]                      o_temperature_centi,
    output logic [31:0]                      o_pressure_fixed,
    output logic                             o_pressure_invalid
);
    import btc_pkg::*;

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_calib_low;
    logic [63:0] r_press_calib_high;
    logic [15:0] r_press_calib_last;
    t_calib      cal;
    logic        item_vld;
    t_item       item;
    logic        item_take;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib       <= '0;
            r_press_calib_low  <= '0;
            r_press_calib_high <= '0;
            r_press_calib_last <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP_CALIB: r_temp_calib       <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_press_calib_low  <= i_cfg_data;
                CFG_PRESS_HIGH: r_press_calib_high <= i_cfg_data;
                CFG_PRESS_LAST: r_press_calib_last <= i_cfg_data[15:0];
            endcase
        end
    end

    // unpack calibration words
    always_comb begin
        cal.t1 = r_temp_calib[15:0];
        cal.t2 = r_temp_calib[31:16];
        cal.t3 = r_temp_calib[47:32];
        cal.p1 = r_press_calib_low[15:0];
        cal.p2 = r_press_calib_low[31:16];
        cal.p3 = r_press_calib_low[47:32];
        cal.p4 = r_press_calib_low[63:48];
        cal.p5 = r_press_calib_high[15:0];
        cal.p6 = r_press_calib_high[31:16];
        cal.p7 = r_press_calib_high[47:32];
        cal.p8 = r_press_calib_high[63:48];
        cal.p9 = r_press_calib_last;
    end

    btc_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk,
        .i_rst_n,
        .i_t1              (cal.t1),
        .i_push            (push),
        .o_full            (full),
        .i_pressure_raw,
        .i_temperature_raw,
        .o_item_vld        (item_vld),
        .o_item            (item),
        .i_item_take       (item_take)
    );

    btc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_cal              (cal),
        .i_item_vld         (item_vld),
        .i_item             (item),
        .o_item_take        (item_take),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_temperature_centi,
        .o_pressure_fixed,
        .o_pressure_invalid
    );

    // checks
    `BTC_ASSERT_NOW(a_inv_zero, !empty && o_pressure_invalid |-> o_pressure_fixed == 32'd0, "invalid result carries nonzero pressure")
    `BTC_ASSERT_NEXT(a_stall_full, full && !empty && !pop, full, "queue drained while pipeline stalled")
    `BTC_ASSERT_NOW(a_full_cause, $rose(full) |-> $past(push), "queue filled without a push")
endmodule

/* rtl/core/btc_mul.sv */
// Low 64 bits of a 64x64 product, two stages: 32x32 partials, then sum
module btc_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] m_ll;
    logic [63:0] m_lh;
    logic [63:0] m_hl;

    assign m_ll = i_a[31:0] * i_b[31:0];
    assign m_lh = i_a[31:0] * i_b[63:32];
    assign m_hl = i_a[63:32] * i_b[31:0];

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= m_ll;
            r_lh <= m_lh[31:0];
            r_hl <= m_hl[31:0];
        end
    end

    // recombine, cross terms only matter in the upper word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;
endmodule

/* rtl/core/btc_div.sv */
// Unsigned 64/64 restoring divider, one quotient bit per stage
module btc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo
);
    localparam int W = 64;

    logic [W-1:0] r_rem [0:W-1];
    logic [W-1:0] r_quo [0:W-1];
    logic [W-1:0] r_den [0:W-1];
    logic [W-1:0] s_rem [0:W-1];
    logic [W-1:0] s_quo [0:W-1];
    logic [W-1:0] s_den [0:W-1];
    logic [W:0]   n_t   [0:W-1];
    logic [W-1:0] n_rem [0:W-1];
    logic [W-1:0] n_quo [0:W-1];

    // stage inputs: first stage from ports, the rest from the stage before
    always_comb begin
        s_rem[0] = '0;
        s_quo[0] = i_num;
        s_den[0] = i_den;
        for (int k = 1; k < W; k++) begin
            s_rem[k] = r_rem[k-1];
            s_quo[k] = r_quo[k-1];
            s_den[k] = r_den[k-1];
        end
    end

    // shift in next numerator bit, subtract when it fits
    always_comb begin
        for (int k = 0; k < W; k++) begin
            n_t[k] = {s_rem[k], s_quo[k][W-1]};
            if (n_t[k] >= {1'b0, s_den[k]}) begin
                n_rem[k] = W'(n_t[k] - {1'b0, s_den[k]});
                n_quo[k] = {s_quo[k][W-2:0], 1'b1};
            end else begin
                n_rem[k] = n_t[k][W-1:0];
                n_quo[k] = {s_quo[k][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_quo[W-1];
endmodule

/* rtl/core/btc_front.sv */
// Front end: takes samples, forms the temperature differences, queues them
module btc_front #(
    parameter int QUEUE_DEPTH = btc_pkg::BTC_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_t1,
    input  logic            i_push,
    output logic            o_full,
    input  logic [19:0]     i_pressure_raw,
    input  logic [19:0]     i_temperature_raw,
    output logic            o_item_vld,
    output btc_pkg::t_item  o_item,
    input  logic            i_item_take
);
    import btc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr;
    t_item            cls;

    // classify: the two offsets that feed the temperature multipliers
    always_comb begin
        cls.a     = {1'b0, i_temperature_raw[19:3]} - {1'b0, i_t1, 1'b0};
        cls.b     = {1'b0, i_temperature_raw[19:4]} - {1'b0, i_t1};
        cls.adc_p = i_pressure_raw;
    end

    assign o_full     = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign wr         = i_push && !o_full;
    assign o_item_vld = (r_cnt != '0);
    assign o_item     = r_mem[r_rptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= cls;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_item_take) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({wr, i_item_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

/* rtl/core/btc_back.sv */
// Back end: compensation pipeline, stalls as a whole on the output register
module btc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btc_pkg::t_calib i_cal,
    input  logic            i_item_vld,
    input  btc_pkg::t_item  i_item,
    output logic            o_item_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [31:0]     o_temperature_centi,
    output logic [31:0]     o_pressure_fixed,
    output logic            o_pressure_invalid
);
    import btc_pkg::*;

    localparam int LAST = 84;

    logic          en;
    logic [LAST:0] r_vld;

    // calibration, extended
    logic [31:0] t2_32;
    logic [31:0] t3_32;
    assign t2_32 = sx16_32(i_cal.t2);
    assign t3_32 = sx16_32(i_cal.t3);

    // whole pipeline advances unless a finished result is waiting
    assign en          = !r_vld[LAST] || i_pop;
    assign o_item_take = en && i_item_vld;
    assign o_empty     = !r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_item_vld};
        end
    end

    // temperature path, 32-bit wrapping
    logic [17:0] r0_a;
    logic [16:0] r0_b;
    logic [19:0] r_adcp [0:8];
    logic [31:0] r1_tv1p;
    logic [31:0] r1_bb;
    logic [31:0] r2_tv1;
    logic [31:0] r2_t3p;
    logic [31:0] r3_fine;
    logic [31:0] r_temp [4:LAST];
    logic [63:0] r4_v1;
    logic [31:0] a32;
    logic [31:0] b32;
    logic [63:0] m_tv1;
    logic [63:0] m_bb;
    logic [31:0] bbs;
    logic [63:0] m_t3;
    logic [31:0] temp_sum;

    assign a32      = {{14{r0_a[17]}}, r0_a};
    assign b32      = {{15{r0_b[16]}}, r0_b};
    assign m_tv1    = a32 * t2_32;
    assign m_bb     = b32 * b32;
    assign bbs      = 32'($signed(r1_bb) >>> 12);
    assign m_t3     = bbs * t3_32;
    assign temp_sum = (r3_fine << 2) + r3_fine + 32'd128;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a      <= i_item.a;
            r0_b      <= i_item.b;
            r_adcp[0] <= i_item.adc_p;
            for (int k = 1; k <= 8; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            r1_tv1p   <= m_tv1[31:0];
            r1_bb     <= m_bb[31:0];
            r2_tv1    <= 32'($signed(r1_tv1p) >>> 11);
            r2_t3p    <= m_t3[31:0];
            r3_fine   <= r2_tv1 + 32'($signed(r2_t3p) >>> 14);
            r_temp[4] <= 32'($signed(temp_sum) >>> 8);
            r4_v1     <= sx32_64(r3_fine) - FINE_OFFSET;
            for (int k = 5; k <= LAST; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
        end
    end

    // pressure: first products of v1, then of v1 squared
    logic [63:0] p_sq;
    logic [63:0] p_v1p5;
    logic [63:0] p_v1p2;
    logic [63:0] p_sqp6;
    logic [63:0] p_sqp3;
    logic [63:0] r7_v1p5;
    logic [63:0] r8_v1p5;
    logic [63:0] r7_v1p2;
    logic [63:0] r8_v1p2;

    btc_mul u_mul_sq (.i_clk, .i_en(en), .i_a(r4_v1), .i_b(r4_v1), .o_p(p_sq));
    btc_mul u_mul_p5 (.i_clk, .i_en(en), .i_a(r4_v1), .i_b(sx16_64(i_cal.p5)),
                      .o_p(p_v1p5));
    btc_mul u_mul_p2 (.i_clk, .i_en(en), .i_a(r4_v1), .i_b(sx16_64(i_cal.p2)),
                      .o_p(p_v1p2));
    btc_mul u_mul_p6 (.i_clk, .i_en(en), .i_a(p_sq), .i_b(sx16_64(i_cal.p6)),
                      .o_p(p_sqp6));
    btc_mul u_mul_p3 (.i_clk, .i_en(en), .i_a(p_sq), .i_b(sx16_64(i_cal.p3)),
                      .o_p(p_sqp3));

    // numerator and divisor terms
    logic [63:0] r9_v2;
    logic [63:0] r9_y;
    logic [63:0] r9_pt;
    logic [63:0] r10_nd;
    logic [63:0] p_x;
    logic [63:0] p_num;
    logic [63:0] r12_den;
    logic [20:0] p_rem;

    assign p_rem = PRESS_FULL - {1'b0, r_adcp[8]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_v1p5 <= p_v1p5;
            r8_v1p5 <= r7_v1p5;
            r7_v1p2 <= p_v1p2;
            r8_v1p2 <= r7_v1p2;
            r9_v2   <= p_sqp6 + (r8_v1p5 << P5_SHIFT) + (sx16_64(i_cal.p4) << P4_SHIFT);
            r9_y    <= 64'($signed(p_sqp3) >>> 8) + (r8_v1p2 << 12) + DEN_BIAS;
            r9_pt   <= {43'd0, p_rem} << 31;
            r10_nd  <= r9_pt - r9_v2;
            r12_den <= 64'($signed(p_x) >>> 33);
        end
    end

    btc_mul u_mul_p1 (.i_clk, .i_en(en), .i_a(r9_y), .i_b({48'd0, i_cal.p1}), .o_p(p_x));
    btc_mul u_mul_k  (.i_clk, .i_en(en), .i_a(r10_nd), .i_b(PRESS_SCALE), .o_p(p_num));

    // signed division through magnitudes
    logic [63:0] r13_num;
    logic [63:0] r13_den;
    logic        r_neg [13:77];
    logic        r_inv [13:LAST];
    logic [63:0] p_quo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_num   <= p_num[63] ? (64'd0 - p_num) : p_num;
            r13_den   <= r12_den[63] ? (64'd0 - r12_den) : r12_den;
            r_neg[13] <= p_num[63] ^ r12_den[63];
            r_inv[13] <= (r12_den == '0);
            for (int k = 14; k <= 77; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 14; k <= LAST; k++) begin
                r_inv[k] <= r_inv[k-1];
            end
        end
    end

    btc_div u_div (.i_clk, .i_en(en), .i_num(r13_num), .i_den(r13_den), .o_quo(p_quo));

    // second-order correction and final scaling
    logic [63:0] r_q [78:82];
    logic [63:0] ps;
    logic [63:0] r79_ps;
    logic [63:0] r80_ps;
    logic [63:0] p_p9ps;
    logic [63:0] p_p8q;
    logic [63:0] r81_p8q;
    logic [63:0] r82_p8q;
    logic [63:0] p_w1;
    logic [63:0] r83_s;
    logic [31:0] r84_pf;
    logic [63:0] pres;

    assign ps   = 64'($signed(r_q[78]) >>> 13);
    assign pres = 64'($signed(r83_s) >>> 8) + (sx16_64(i_cal.p7) << 4);

    btc_mul u_mul_p9 (.i_clk, .i_en(en), .i_a(ps), .i_b(sx16_64(i_cal.p9)), .o_p(p_p9ps));
    btc_mul u_mul_p8 (.i_clk, .i_en(en), .i_a(r_q[78]), .i_b(sx16_64(i_cal.p8)),
                      .o_p(p_p8q));
    btc_mul u_mul_ps (.i_clk, .i_en(en), .i_a(p_p9ps), .i_b(r80_ps), .o_p(p_w1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[78] <= r_neg[77] ? (64'd0 - p_quo) : p_quo;
            for (int k = 79; k <= 82; k++) begin
                r_q[k] <= r_q[k-1];
            end
            r79_ps  <= ps;
            r80_ps  <= r79_ps;
            r81_p8q <= p_p8q;
            r82_p8q <= r81_p8q;
            r83_s   <= r_q[82] + 64'($signed(p_w1) >>> 25) + 64'($signed(r82_p8q) >>> 19);
            r84_pf  <= r_inv[83] ? 32'd0 : pres[31:0];
        end
    end

    assign o_temperature_centi = r_temp[LAST];
    assign o_pressure_fixed    = r84_pf;
    assign o_pressure_invalid  = r_inv[LAST];
endmodule

/* test/baro_temp_compensation_tb.sv */
module baro_temp_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_fixed;
        logic        press_invalid;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [19:0] i_pressure_raw;
    logic [19:0] i_temperature_raw;
    logic        empty;
    logic        pop;
    logic [31:0] o_temperature_centi;
    logic [31:0] o_pressure_fixed;
    logic        o_pressure_invalid;

    // Local copy of the calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_p9;

    t_reading reading_q[$];
    int       mismatches;
    bit       idle_on;
    int       stall_left;
    int       quiet_cycles;

    baro_temp_compensation uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .push                (push),
        .full                (full),
        .i_pressure_raw      (i_pressure_raw),
        .i_temperature_raw   (i_temperature_raw),
        .empty               (empty),
        .pop                 (pop),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_fixed    (o_pressure_fixed),
        .o_pressure_invalid  (o_pressure_invalid)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Integer compensation of one raw sample pair
    function automatic t_reading compensate(input logic [19:0] adc_p, input logic [19:0] adc_t);
        t_reading r;
        bit [31:0] t1, t2, t3, a, b, m, tv1, tv2, fine, temp;
        bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        bit [63:0] v1, v2, den, num, ma, mb, q, p, ps, w1, w2;
        bit        neg;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_press_low[15:0]};
        p2 = sext16(cal_press_low[31:16]);
        p3 = sext16(cal_press_low[47:32]);
        p4 = sext16(cal_press_low[63:48]);
        p5 = sext16(cal_press_high[15:0]);
        p6 = sext16(cal_press_high[31:16]);
        p7 = sext16(cal_press_high[47:32]);
        p8 = sext16(cal_press_high[63:48]);
        p9 = sext16(cal_p9);

        // temperature, 32-bit wrapping
        a = {15'd0, adc_t[19:3]} - (t1 << 1);
        m = a * t2;
        tv1 = $signed(m) >>> 11;
        b = {16'd0, adc_t[19:4]} - t1;
        m = b * b;
        m = $signed(m) >>> 12;
        m = m * t3;
        tv2 = $signed(m) >>> 14;
        fine = tv1 + tv2;
        m = fine * 32'd5 + 32'd128;
        temp = $signed(m) >>> 8;
        r.temp_centi = temp;

        // pressure, 64-bit wrapping
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        den = v1 * v1 * p3;
        den = $signed(den) >>> 8;
        den = den + ((v1 * p2) << 12);
        den = ((64'd1 << 47) + den) * p1;
        den = $signed(den) >>> 33;
        if (den == 64'd0) begin
            r.press_fixed   = '0;
            r.press_invalid = 1'b1;
        end else begin
            p = 64'd1048576 - {44'd0, adc_p};
            num = ((p << 31) - v2) * 64'd3125;
            neg = num[63] ^ den[63];
            ma = num[63] ? (64'd0 - num) : num;
            mb = den[63] ? (64'd0 - den) : den;
            q = ma / mb;
            p = neg ? (64'd0 - q) : q;
            ps = $signed(p) >>> 13;
            w1 = p9 * ps * ps;
            w1 = $signed(w1) >>> 25;
            w2 = p8 * p;
            w2 = $signed(w2) >>> 19;
            p = p + w1 + w2;
            p = $signed(p) >>> 8;
            p = p + (p7 << 4);
            r.press_fixed   = p[31:0];
            r.press_invalid = 1'b0;
        end
        return r;
    endfunction

    // Receiver: random pop stalls, result check against oldest expectation
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left <= 0;
        end else begin
            if (pop && !empty) begin
                if (reading_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: temp %0d press %h inv %b",
                                 $signed(o_temperature_centi), o_pressure_fixed,
                                 o_pressure_invalid);
                end else begin
                    exp_r = reading_q.pop_front();
                    if (exp_r.temp_centi !== o_temperature_centi
                        || exp_r.press_fixed !== o_pressure_fixed
                        || exp_r.press_invalid !== o_pressure_invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: temp exp %0d got %0d, press exp %h got %h, inv exp %b got %b",
                                     $signed(exp_r.temp_centi), $signed(o_temperature_centi),
                                     exp_r.press_fixed, o_pressure_fixed,
                                     exp_r.press_invalid, o_pressure_invalid);
                    end
                end
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("baro_temp_compensation_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one sample pair; optional idle burst first
    task automatic send_sample(input logic [19:0] adc_p, input logic [19:0] adc_t);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pressure_raw <= adc_p;
        i_temperature_raw <= adc_t;
        do @(posedge i_clk); while (full);
        reading_q.push_back(compensate(adc_p, adc_t));
    endtask

    // Stop sending until every result is back and the pipeline is quiet
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (reading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four calibration registers back to back
    task automatic load_calib(input logic [47:0] tc, input logic [63:0] pl,
                              input logic [63:0] ph, input logic [15:0] p9);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TEMP_CALIB;
        i_cfg_data <= {$urandom(), $urandom()} & 64'h0 | {16'd0, tc};
        @(posedge i_clk);
        cal_temp = tc;
        i_cfg_idx <= CFG_PRESS_LOW;
        i_cfg_data <= pl;
        @(posedge i_clk);
        cal_press_low = pl;
        i_cfg_idx <= CFG_PRESS_HIGH;
        i_cfg_data <= ph;
        @(posedge i_clk);
        cal_press_high = ph;
        i_cfg_idx <= CFG_PRESS_LAST;
        i_cfg_data <= {48'd0, p9};
        @(posedge i_clk);
        cal_p9 = p9;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [19:0] rand20();
        return 20'($urandom());
    endfunction

    // Reset calibration: divisor is zero, so pressure is flagged invalid
    task automatic test_zero_calib();
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd415148, 20'd519888);
        wait_drained();
    endtask

    // Typical calibration with raw extremes
    task automatic test_typical_calib();
        load_calib({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        send_sample(20'd415148, 20'd519888);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'h80000, 20'h80000);
        send_sample(20'd327680, 20'd524288);
        wait_drained();
    endtask

    // Calibration words at their extremes
    task automatic test_extreme_calib();
        load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h5A5A5, 20'hA5A5A);
        wait_drained();
        load_calib({16'h8000, 16'h8000, 16'h0000}, 64'h8000_8000_8000_FFFF,
                   64'h8000_8000_8000_8000, 16'h8000);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'h12345, 20'h6789A);
        wait_drained();
        load_calib({16'h7FFF, 16'h7FFF, 16'h0001}, 64'h7FFF_7FFF_7FFF_0001,
                   64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        wait_drained();
    endtask

    // Random samples under several random calibrations, optionally with p1 forced to zero
    task automatic test_random(input int phases, input int per_phase, input bit zero_p1);
        logic [63:0] pl;
        for (int ph = 0; ph < phases; ph++) begin
            pl = {$urandom(), $urandom()};
            if (zero_p1)
                pl[15:0] = 16'd0;
            else if (pl[15:0] == 16'd0)
                pl[15:0] = 16'd1;
            load_calib(48'({$urandom(), $urandom()}), pl,
                       {$urandom(), $urandom()}, 16'($urandom()));
            for (int k = 0; k < per_phase; k++)
                send_sample(rand20(), rand20());
            wait_drained();
        end
    endtask

    // Near-typical calibration, random samples
    task automatic test_near_typical(input int count);
        load_calib({16'hFC18 ^ 16'($urandom_range(0, 255)), 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        for (int k = 0; k < count; k++)
            send_sample(rand20(), rand20());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TEMP_CALIB;
        i_cfg_data = '0;
        push = 1'b0;
        i_pressure_raw = '0;
        i_temperature_raw = '0;
        cal_temp = '0;
        cal_press_low = '0;
        cal_press_high = '0;
        cal_p9 = '0;
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_calib();
        test_typical_calib();
        test_extreme_calib();
        test_random(6, 200, 1'b0);
        test_random(1, 40, 1'b1);
        test_near_typical(200);
        wait_drained();
        idle_on = 1'b0;
        test_near_typical(200);
        wait_drained();

        if (mismatches == 0 && reading_q.size() == 0) begin
            $display("baro_temp_compensation_tb: clean");
        end else begin
            $display("baro_temp_compensation_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/btc_pkg.sv
rtl/core/btc_mul.sv
rtl/core/btc_div.sv
rtl/core/btc_front.sv
rtl/core/btc_back.sv
rtl/core/baro_temp_compensation.sv
test/baro_temp_compensation_tb.sv
